>>> hdl/jmss_pkg.sv
// Package for the joint move segment sequencer.
// Holds sizes, operation and status codes, the sequencer state type and helpers.
// No dependencies.
package jmss_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int QADDR_W     = 6;
  localparam int MAX_JOINTS  = 16;
  localparam int CNT_W       = 7;
  localparam int JOINT_W     = 4;
  localparam int DELTA_W     = 26;
  localparam int DUR_W       = 16;
  localparam int ANGLE_W     = 32;
  localparam int CMD_W       = JOINT_W + DELTA_W + DUR_W;
  localparam int DIV_W       = 49;
  localparam int DIV_CNT_W   = 6;

  // round(2^32 * pi / 180)
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

  // request operations
  localparam logic [2:0] OP_LOAD  = 3'd0;
  localparam logic [2:0] OP_INIT  = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // result status codes
  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_FINISHED  = 3'd1;
  localparam logic [2:0] STS_BAD_JOINT = 3'd2;
  localparam logic [2:0] STS_EMPTY     = 3'd3;
  localparam logic [2:0] STS_BAD_FIRST = 3'd4;
  localparam logic [2:0] STS_FULL      = 3'd5;
  localparam logic [2:0] STS_BUSY      = 3'd6;

  // configuration register byte addresses
  localparam logic [2:0] REG_JOINT_COUNT = 3'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK_CHK,
    ST_ARM_CHK,
    ST_ROUND,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FIX
  } state_t;

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sd2147483647;
    lo = -35'sd2147483648;
    if (v > hi) sat32 = 32'sh7fffffff;
    else if (v < lo) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

>>> hdl/jmss_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module jmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

>>> hdl/joint_move_segment_sequencer_top.sv
// Joint move segment sequencer top level: command queue, playback sequencer,
// shared multiplier and bit-serial divider. Depends on jmss_pkg and jmss_ram.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  op, joint_index, delta_degrees,
//                                            duration_ms, initial_angle, tick_ms
//   out      output     out_valid/out_stall  status, moved_joint, joint_angle,
//                                            segment_number, is_running
//   cfg      APB        psel/penable/pready  joint_count at byte address 0
//
// Load, init, stop, unused ops and idle ticks go from decode straight to the
// result; a start with a non-empty queue also arms the first segment; a tick
// checks its segment and then fails, finishes, advances or interpolates with
// the 49-step divider. One request is in flight at a time; in_stall is high
// until it is done. A stalled result holds the sequencer in its last state
// until the output is free. rst is synchronous, active high, and clears all
// control and angle state.
module joint_move_segment_sequencer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    op,
  input  logic [jmss_pkg::JOINT_W-1:0]  joint_index,
  input  logic signed [jmss_pkg::DELTA_W-1:0] delta_degrees,
  input  logic [jmss_pkg::DUR_W-1:0]    duration_ms,
  input  logic signed [jmss_pkg::ANGLE_W-1:0] initial_angle,
  input  logic [9:0]                    tick_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [jmss_pkg::JOINT_W-1:0]  moved_joint,
  output logic signed [jmss_pkg::ANGLE_W-1:0] joint_angle,
  output logic [jmss_pkg::CNT_W-1:0]    segment_number,
  output logic                          is_running,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import jmss_pkg::*;

  state_t state, state_next;

  logic [4:0] joint_count;

  // latched request
  logic [2:0]                op_r;
  logic [JOINT_W-1:0]        ji_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic [DUR_W-1:0]          dur_r;
  logic signed [ANGLE_W-1:0] init_r;
  logic [9:0]                tms_r;

  // playback state
  logic [CNT_W-1:0]          cmd_count;
  logic [CNT_W-1:0]          cur_seg;
  logic signed [ANGLE_W-1:0] start_ang [MAX_JOINTS];
  logic signed [ANGLE_W-1:0] live_ang [MAX_JOINTS];
  logic signed [ANGLE_W-1:0] begin_ang;
  logic signed [ANGLE_W-1:0] goal_ang;
  logic [31:0]               elapsed;
  logic                      playing;

  // work registers
  logic signed [60:0]        prod;
  logic [DIV_W-1:0]          dq;
  logic [DUR_W-1:0]          rem;
  logic [DIV_CNT_W-1:0]      div_cnt;
  logic                      div_neg;
  logic                      interp_pend;
  logic [DUR_W-1:0]          seg_dur;
  logic [2:0]                err_status;
  logic                      from_start;
  logic [2:0]                res_status;
  logic [JOINT_W-1:0]        res_moved;
  logic signed [ANGLE_W-1:0] res_angle;

  // command store
  logic               ram_wr_en;
  logic [QADDR_W-1:0] ram_wr_addr;
  logic [CMD_W-1:0]   ram_wr_data;
  logic               ram_rd_en;
  logic [QADDR_W-1:0] ram_rd_addr;
  logic [CMD_W-1:0]   ram_rd_data;

  jmss_ram #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  logic [JOINT_W-1:0]        rd_joint;
  logic signed [DELTA_W-1:0] rd_delta;
  logic [DUR_W-1:0]          rd_dur;
  assign rd_joint = ram_rd_data[CMD_W-1 -: JOINT_W];
  assign rd_delta = ram_rd_data[DUR_W +: DELTA_W];
  assign rd_dur   = ram_rd_data[DUR_W-1:0];

  // joint validity against the effective joint count
  logic [4:0] joints_present;
  logic       rd_joint_ok;
  assign joints_present = (joint_count < 5'(MAX_JOINTS)) ? joint_count : 5'(MAX_JOINTS);
  assign rd_joint_ok    = {1'b0, rd_joint} < joints_present;

  // tick decisions
  logic [32:0]      tick_sum;
  logic [31:0]      e_sat;
  logic             tick_bad;
  logic             seg_end;
  logic [CNT_W-1:0] seg_inc;
  logic             last_seg;
  logic             seg_valid;
  assign tick_sum  = {1'b0, elapsed} + 33'(tms_r);
  assign e_sat     = tick_sum[32] ? 32'hffffffff : tick_sum[31:0];
  assign seg_valid = cur_seg < cmd_count;
  assign tick_bad  = !seg_valid || !rd_joint_ok;
  assign seg_end   = (rd_dur == '0) || (e_sat >= {16'b0, rd_dur});
  assign seg_inc   = cur_seg + 7'd1;
  assign last_seg  = seg_inc >= cmd_count;

  // shared multiplier
  logic signed [32:0] diff;
  logic signed [32:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [60:0] mul_p;
  assign diff = 33'(goal_ang) - 33'(begin_ang);
  always_comb begin
    if (state == ST_ARM_CHK) begin
      mul_a = 33'(rd_delta);
      mul_b = 28'(DEG_TO_RAD_Q32);
    end else begin
      mul_a = diff;
      mul_b = {12'b0, e_sat[15:0]};
    end
  end
  assign mul_p = 61'(mul_a) * 61'(mul_b);

  // degrees to radians rounding, half away from zero
  logic [60:0]        mag;
  logic [60:0]        mag_rnd;
  logic signed [34:0] rad;
  logic signed [ANGLE_W-1:0] goal_new;
  assign mag      = prod[60] ? 61'(-prod) : 61'(prod);
  assign mag_rnd  = (mag + 61'h80000000) >> 32;
  assign rad      = prod[60] ? -35'(mag_rnd[28:0]) : 35'(mag_rnd[28:0]);
  assign goal_new = sat32(35'(begin_ang) + rad);

  // one restoring divider step
  logic [DUR_W:0]   r2;
  logic             q_bit;
  logic [DUR_W-1:0] rem_step;
  assign r2       = {rem, dq[DIV_W-1]};
  assign q_bit    = r2 >= {1'b0, seg_dur};
  assign rem_step = q_bit ? DUR_W'(r2 - {1'b0, seg_dur}) : r2[DUR_W-1:0];

  // quotient sign fix and interpolated angle
  logic signed [34:0]        step;
  logic signed [ANGLE_W-1:0] interp;
  assign step   = div_neg ? -35'({1'b0, dq[33:0]}) : 35'({1'b0, dq[33:0]});
  assign interp = sat32(35'(begin_ang) + step);

  logic [60:0] prod_mag;
  assign prod_mag = prod[60] ? 61'(-prod) : 61'(prod);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_JOINT_COUNT) ? {27'b0, joint_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) joint_count <= 5'd6;
    else if (psel && penable && pwrite && paddr == REG_JOINT_COUNT)
      joint_count <= pwdata[4:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (op_r == OP_START && cmd_count != '0) state_next = ST_ARM_CHK;
        else if (op_r == OP_TICK && playing && seg_valid) state_next = ST_TICK_CHK;
        else state_next = ST_FIX;
      end
      ST_TICK_CHK: begin
        if (tick_bad) state_next = ST_FIX;
        else if (!seg_end) state_next = ST_DIV_LOAD;
        else if (last_seg) state_next = ST_FIX;
        else state_next = ST_ARM_CHK;
      end
      ST_ARM_CHK:  state_next = rd_joint_ok ? ST_ROUND : ST_FIX;
      ST_ROUND:    state_next = ST_FIX;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV:      if (div_cnt == 6'd1) state_next = ST_FIX;
      ST_FIX:      if (out_free && !interp_pend) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // command store controls
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cmd_count[QADDR_W-1:0];
    ram_wr_data = {ji_r, delta_r, dur_r};
    ram_rd_en   = 1'b0;
    ram_rd_addr = cur_seg[QADDR_W-1:0];
    unique case (state)
      ST_DECODE: begin
        if (op_r == OP_LOAD && !playing && cmd_count < CNT_W'(QUEUE_DEPTH))
          ram_wr_en = 1'b1;
        if (op_r == OP_START) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = '0;
        end else if (op_r == OP_TICK) begin
          ram_rd_en = 1'b1;
        end
      end
      ST_TICK_CHK: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = seg_inc[QADDR_W-1:0];
      end
      default: ;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // state register and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_FIX && state_next == ST_IDLE)
        out_valid <= 1'b1;
      else if (!out_stall)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIX && state_next == ST_IDLE) begin
      status         <= res_status;
      moved_joint    <= res_moved;
      joint_angle    <= res_angle;
      segment_number <= cur_seg;
      is_running     <= playing;
    end
  end

  // request latch and working datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r    <= op;
      ji_r    <= joint_index;
      delta_r <= delta_degrees;
      dur_r   <= duration_ms;
      init_r  <= initial_angle;
      tms_r   <= tick_ms;
    end
    unique case (state)
      ST_TICK_CHK: begin
        prod    <= mul_p;
        seg_dur <= rd_dur;
      end
      ST_ARM_CHK:  prod <= mul_p;
      ST_DIV_LOAD: begin
        dq      <= prod_mag[DIV_W-1:0];
        rem     <= '0;
        div_cnt <= DIV_CNT_W'(DIV_W);
        div_neg <= prod[60];
      end
      ST_DIV: begin
        dq      <= {dq[DIV_W-2:0], q_bit};
        rem     <= rem_step;
        div_cnt <= div_cnt - 6'd1;
      end
      default: ;
    endcase
  end

  // playback state
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_count   <= '0;
      cur_seg     <= '0;
      playing     <= 1'b0;
      begin_ang   <= '0;
      goal_ang    <= '0;
      elapsed     <= '0;
      interp_pend <= 1'b0;
      for (int i = 0; i < MAX_JOINTS; i++) begin
        start_ang[i] <= '0;
        live_ang[i]  <= '0;
      end
    end else begin
      unique case (state)
        ST_DECODE: begin
          res_status <= STS_OK;
          res_moved  <= '0;
          res_angle  <= '0;
          case (op_r)
            OP_LOAD: begin
              if (playing) res_status <= STS_BUSY;
              else if (cmd_count >= CNT_W'(QUEUE_DEPTH)) res_status <= STS_FULL;
              else cmd_count <= cmd_count + 7'd1;
            end
            OP_INIT: start_ang[ji_r] <= init_r;
            OP_START: begin
              playing    <= 1'b0;
              cur_seg    <= '0;
              begin_ang  <= '0;
              goal_ang   <= '0;
              elapsed    <= '0;
              err_status <= STS_BAD_FIRST;
              from_start <= 1'b1;
              if (cmd_count == '0) begin
                res_status <= STS_EMPTY;
                for (int i = 0; i < MAX_JOINTS; i++) live_ang[i] <= '0;
              end else begin
                for (int i = 0; i < MAX_JOINTS; i++) live_ang[i] <= start_ang[i];
              end
            end
            OP_TICK: begin
              if (playing && !seg_valid) begin
                res_status <= STS_BAD_JOINT;
                playing    <= 1'b0;
                cmd_count  <= '0;
                cur_seg    <= '0;
                begin_ang  <= '0;
                goal_ang   <= '0;
                elapsed    <= '0;
                for (int i = 0; i < MAX_JOINTS; i++) live_ang[i] <= '0;
              end
            end
            OP_STOP: begin
              playing   <= 1'b0;
              cmd_count <= '0;
              cur_seg   <= '0;
              begin_ang <= '0;
              goal_ang  <= '0;
              elapsed   <= '0;
              for (int i = 0; i < MAX_JOINTS; i++) live_ang[i] <= '0;
            end
            default: ;
          endcase
        end
        ST_TICK_CHK: begin
          if (tick_bad) begin
            res_status <= STS_BAD_JOINT;
            playing    <= 1'b0;
            cmd_count  <= '0;
            cur_seg    <= '0;
            begin_ang  <= '0;
            goal_ang   <= '0;
            elapsed    <= '0;
            for (int i = 0; i < MAX_JOINTS; i++) live_ang[i] <= '0;
          end else begin
            res_moved <= rd_joint;
            elapsed   <= e_sat;
            if (seg_end) begin
              res_angle          <= goal_ang;
              live_ang[rd_joint] <= goal_ang;
              if (last_seg) begin
                playing    <= 1'b0;
                cur_seg    <= cmd_count;
                res_status <= STS_FINISHED;
              end else begin
                cur_seg    <= seg_inc;
                err_status <= STS_BAD_JOINT;
                from_start <= 1'b0;
              end
            end
          end
        end
        ST_ARM_CHK: begin
          if (!rd_joint_ok) begin
            res_status <= err_status;
            playing    <= 1'b0;
            cmd_count  <= '0;
            cur_seg    <= '0;
            begin_ang  <= '0;
            goal_ang   <= '0;
            elapsed    <= '0;
            for (int i = 0; i < MAX_JOINTS; i++) live_ang[i] <= '0;
          end else begin
            begin_ang <= live_ang[rd_joint];
          end
        end
        ST_ROUND: begin
          goal_ang <= goal_new;
          elapsed  <= '0;
          if (from_start) playing <= 1'b1;
        end
        ST_DIV: begin
          // last divider step: write the interpolated angle next cycle
          if (div_cnt == 6'd1) interp_pend <= 1'b1;
        end
        ST_FIX: begin
          if (interp_pend) begin
            res_angle           <= interp;
            live_ang[res_moved] <= interp;
            interp_pend         <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
